FILE: rtl/core/p80_pkg.sv
// ----------------------------------------------------------------------------
// p80_pkg
// Shared types, constants and round functions for the PRESENT-80 encryptor.
// ----------------------------------------------------------------------------
package p80_pkg;

  localparam int ROUNDS    = 31;
  localparam int BLK_W     = 64;
  localparam int KEY_W     = 80;
  localparam int RC_W      = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b1;

  typedef logic [3:0] nib_t;

  typedef struct packed {
    logic               valid;
    logic [RC_W-1:0]    rc;
    logic [KEY_W-1:0]   key;
    logic [BLK_W-1:0]   state;
  } p80_beat_t;

  function automatic nib_t sbox(input nib_t x);
    nib_t y;
    case (x)
      4'h0: y = 4'hC;
      4'h1: y = 4'h5;
      4'h2: y = 4'h6;
      4'h3: y = 4'hB;
      4'h4: y = 4'h9;
      4'h5: y = 4'h0;
      4'h6: y = 4'hA;
      4'h7: y = 4'hD;
      4'h8: y = 4'h3;
      4'h9: y = 4'hE;
      4'hA: y = 4'hF;
      4'hB: y = 4'h8;
      4'hC: y = 4'h4;
      4'hD: y = 4'h7;
      4'hE: y = 4'h1;
      4'hF: y = 4'h2;
      default: y = 4'h0;
    endcase
    return y;
  endfunction

  function automatic logic [BLK_W-1:0] sub_layer(input logic [BLK_W-1:0] s);
    logic [BLK_W-1:0] r;
    for (int n = 0; n < BLK_W / 4; n++) begin
      r[4*n +: 4] = sbox(s[4*n +: 4]);
    end
    return r;
  endfunction

  // bit i moves to 16*i mod 63, bit 63 stays
  function automatic logic [BLK_W-1:0] perm_layer(input logic [BLK_W-1:0] s);
    logic [BLK_W-1:0] r;
    r[BLK_W-1] = s[BLK_W-1];
    for (int i = 0; i < BLK_W - 1; i++) begin
      r[(16 * i) % (BLK_W - 1)] = s[i];
    end
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] key_update(input logic [KEY_W-1:0] k,
                                                   input logic [RC_W-1:0]  rc);
    logic [KEY_W-1:0] r;
    r = {k[18:0], k[KEY_W-1:19]};
    r[KEY_W-1 -: 4] = sbox(r[KEY_W-1 -: 4]);
    r[19:15] = r[19:15] ^ rc;
    return r;
  endfunction

endpackage

FILE: rtl/core/p80_round_cell.sv
// ----------------------------------------------------------------------------
// p80_round_cell
// One PRESENT round: add round key, S-box layer, bit permutation, key update.
// ----------------------------------------------------------------------------
module p80_round_cell
  import p80_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  p80_beat_t beat_i,
  output p80_beat_t beat_o
);

  logic             valid_r;
  logic [RC_W-1:0]  rc_r;
  logic [KEY_W-1:0] key_r;
  logic [BLK_W-1:0] state_r;

  logic [BLK_W-1:0] state_nxt;
  logic [KEY_W-1:0] key_nxt;
  logic [RC_W-1:0]  rc_nxt;

  always_comb begin
    state_nxt = perm_layer(sub_layer(beat_i.state ^ beat_i.key[KEY_W-1 -: BLK_W]));
    key_nxt   = key_update(beat_i.key, beat_i.rc);
    rc_nxt    = beat_i.rc + RC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= beat_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      state_r <= state_nxt;
      key_r   <= key_nxt;
      rc_r    <= rc_nxt;
    end
  end

  assign beat_o = '{valid: valid_r, rc: rc_r, key: key_r, state: state_r};

endmodule

FILE: rtl/core/present80_block_encrypt.sv
// ----------------------------------------------------------------------------
// present80_block_encrypt
// PRESENT-80 block encryption as a chain of 31 registered round cells.
// ----------------------------------------------------------------------------
// One 64-bit block is taken per cycle while in_tready is high, and its
// ciphertext leaves the last round cell. Each round cell holds one block with
// its own copy of the key register and round counter, so up to 31 blocks
// are in flight. Final key whitening is applied at the output of the last
// cell. The whole chain advances together: when the output beat is held by
// out_tready low, no cell moves and in_tready drops. Write the key (index 0:
// key bits 79..16, index 1: key bits 15..0) only while the chain is empty.
module present80_block_encrypt
  import p80_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BLK_W-1:0]     cfg_wdata,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [BLK_W-1:0]     in_tdata,   // [63:0] plaintext
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [BLK_W-1:0]     out_tdata   // [63:0] ciphertext
);

  logic [BLK_W-1:0]     key_high_r;
  logic [KEY_W-BLK_W-1:0] key_low_r;
  logic                 en;
  p80_beat_t            chain [ROUNDS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_HIGH: key_high_r <= cfg_wdata;
        REG_KEY_LOW:  key_low_r  <= cfg_wdata[KEY_W-BLK_W-1:0];
        default: ;
      endcase
    end
  end

  assign en        = !chain[ROUNDS].valid || out_tready;
  assign in_tready = en;

  assign chain[0] = '{valid: in_tvalid, rc: RC_W'(1),
                      key: {key_high_r, key_low_r}, state: in_tdata};

  for (genvar g = 0; g < ROUNDS; g++) begin : g_round
    p80_round_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .beat_i (chain[g]),
      .beat_o (chain[g+1])
    );
  end

  assign out_tvalid = chain[ROUNDS].valid;
  assign out_tdata  = chain[ROUNDS].state ^ chain[ROUNDS].key[KEY_W-1 -: BLK_W];

endmodule

FILE: test/present80_check.sv
// ----------------------------------------------------------------------------
// present80_check
// Watches the key port and both streams of the PRESENT-80 encryptor, computes
// the ciphertext of every accepted plaintext beat under the key loaded at the
// time, and compares each output beat in order against it.
// ----------------------------------------------------------------------------
module present80_check
  import p80_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BLK_W-1:0]     cfg_wdata,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [BLK_W-1:0]     in_tdata,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [BLK_W-1:0]     out_tdata,
  output int                   errors,
  output int                   pending,
  output int                   blocks_done
);

  // nibble n holds S(n)
  localparam logic [63:0] SBOX_TBL = 64'h2174_8FE3_DA09_B65C;

  logic [KEY_W-1:0] cipher_key;
  logic [BLK_W-1:0] ciphertext_q[$];
  logic [BLK_W-1:0] want_ct;

  function automatic logic [BLK_W-1:0] present_encrypt(input logic [BLK_W-1:0] pt,
                                                        input logic [KEY_W-1:0] key);
    logic [BLK_W-1:0] s;
    logic [BLK_W-1:0] t;
    logic [KEY_W-1:0] k;
    s = pt;
    k = key;
    for (int r = 1; r <= ROUNDS; r++) begin
      s = s ^ k[79:16];
      for (int n = 0; n < 16; n++) begin
        s[4*n +: 4] = SBOX_TBL[4*s[4*n +: 4] +: 4];
      end
      t[63] = s[63];
      for (int i = 0; i < 63; i++) begin
        t[(16 * i) % 63] = s[i];
      end
      s = t;
      k = {k[18:0], k[79:19]};
      k[79:76] = SBOX_TBL[4*k[79:76] +: 4];
      k[19:15] = k[19:15] ^ 5'(r);
    end
    return s ^ k[79:16];
  endfunction

  // published vectors for the all-zero and all-one key and block
  initial begin
    errors = 0;
    pending = 0;
    blocks_done = 0;
    if (present_encrypt('0, '0) !== 64'h5579_C138_7B22_8445) errors++;
    if (present_encrypt('0, '1) !== 64'hE72C_46C0_F594_5049) errors++;
    if (present_encrypt('1, '0) !== 64'hA112_FFC7_2F68_417B) errors++;
    if (present_encrypt('1, '1) !== 64'h3333_DCD3_2132_10D2) errors++;
    if (errors != 0) $display("%0t: ciphertext predictor fails known vectors", $time);
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      cipher_key = '0;
      ciphertext_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_KEY_HIGH: cipher_key[79:16] = cfg_wdata;
          REG_KEY_LOW:  cipher_key[15:0]  = cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        ciphertext_q.push_back(present_encrypt(in_tdata, cipher_key));
      end
      if (out_tvalid && out_tready) begin
        if (ciphertext_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat: expected none, got %h", $time, out_tdata);
        end else begin
          want_ct = ciphertext_q.pop_front();
          blocks_done++;
          if (out_tdata !== want_ct) begin
            errors++;
            $display("%0t: ciphertext mismatch: expected %h, got %h",
                     $time, want_ct, out_tdata);
          end
        end
      end
    end
    pending = ciphertext_q.size();
  end

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the PRESENT-80 encryptor: corner blocks under reset and extreme
// keys, then random blocks under random keys with idle gaps on both streams,
// a long output stall and full drains. A checker module does the comparing.
// ----------------------------------------------------------------------------
module tb;
  import p80_pkg::*;

  localparam int STALL_LEN  = 150;
  localparam int WATCH_LIM  = 2000;
  localparam int PHASES     = 6;
  localparam int PHASE_BLKS = 105;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BLK_W-1:0]     cfg_wdata;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [BLK_W-1:0]     in_tdata;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [BLK_W-1:0]     out_tdata;

  int errors;
  int pending;
  int blocks_done;
  int key_loads;
  int idle_cycles;
  bit tx_idle;
  bit rx_idle;
  bit stall_req;

  present80_block_encrypt dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  present80_check chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .errors      (errors),
    .pending     (pending),
    .blocks_done (blocks_done)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCH_LIM) begin
        $display("%0t: no beat for %0d cycles", $time, WATCH_LIM);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // output side: random back-pressure, plus one long hold-off on request
  initial begin
    int gap;
    out_tready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (stall_req) begin
        out_tready <= 1'b0;
        repeat (STALL_LEN) @(posedge clk);
        stall_req = 1'b0;
      end
      gap = rx_idle ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send_block(input logic [BLK_W-1:0] pt);
    int gap;
    gap = tx_idle ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pt;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  // low word carries don't-care bits above bit 15
  task automatic load_key(input logic [63:0] hi, input logic [63:0] lo_word);
    cfg_we    <= 1'b1;
    cfg_index <= REG_KEY_HIGH;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_index <= REG_KEY_LOW;
    cfg_wdata <= lo_word;
    @(posedge clk);
    cfg_we    <= 1'b0;
    key_loads++;
  endtask

  function automatic logic [BLK_W-1:0] corner_block(input int n);
    case (n)
      0:       return 64'h0;
      1:       return '1;
      2:       return 64'h8000_0000_0000_0000;
      3:       return 64'h1;
      4:       return 64'h5555_5555_5555_5555;
      5:       return 64'hAAAA_AAAA_AAAA_AAAA;
      default: return 64'h0123_4567_89AB_CDEF;
    endcase
  endfunction

  function automatic logic [BLK_W-1:0] random_block();
    logic [BLK_W-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v = v & (64'hF << (4 * $urandom_range(0, 15)));
      1: v = ~(64'h1 << $urandom_range(0, 63));
      2: v = 64'h1 << $urandom_range(0, 63);
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_KEY_HIGH;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    tx_idle   = 1'b0;
    rx_idle   = 1'b0;
    stall_req = 1'b0;
    key_loads = 0;
    idle_cycles = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // key left at its reset value
    for (int n = 0; n < 7; n++) send_block(corner_block(n));
    drain();
    load_key('1, '1);
    for (int n = 0; n < 7; n++) send_block(corner_block(n));
    drain();
    load_key(64'h0, 64'hA5A5_A5A5_A5A5_FFFF);
    for (int n = 0; n < 4; n++) send_block(corner_block(n));
    drain();
    load_key(64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_0000);
    for (int n = 4; n < 7; n++) send_block(corner_block(n));
    drain();

    for (int p = 0; p < PHASES; p++) begin
      load_key({$urandom, $urandom}, {$urandom, $urandom});
      tx_idle = (p == 1 || p == 3 || p == 5);
      rx_idle = (p == 1 || p == 4 || p == 5);
      for (int i = 0; i < PHASE_BLKS; i++) begin
        if (p == 2 && i == 10) stall_req = 1'b1;
        if (p == 5 && i == 50) drain();
        send_block(random_block());
      end
      drain();
    end

    repeat (40) @(posedge clk);
    $display("Encrypted %0d blocks under %0d key loads, incl. corner keys and blocks,",
             blocks_done, key_loads);
    $display("random gaps on both streams, a long output stall and mid-run drains.");
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
